/* sv/soac_pkg.sv */
`default_nettype none
package soac_pkg;

  localparam int unsigned SCAN_POINTS_DEF = 681;
  localparam int          START_ANGLE_Q16 = -7833780;
  localparam int          ANGLE_STEP_Q16  = 23041;

  // floor(2^22 / 360), quotient estimate is exact or one low
  localparam logic [13:0] DEG_RECIP = 14'd11650;

  localparam logic [15:0]        CRIT_THR_RST   = 16'd250;
  localparam logic [15:0]        MIN_VALID_RST  = 16'd50;
  localparam logic [15:0]        FWD_THR_RST    = 16'd1000;
  localparam logic [14:0]        GAIN_RST       = 15'd768;
  localparam logic signed [15:0] FWD_PITCH_RST  = 16'sd512;
  localparam logic signed [15:0] TURN_CMD_RST   = 16'sd1280;
  localparam logic [9:0]         CONE_FIRST_RST = 10'd213;
  localparam logic [9:0]         CONE_LAST_RST  = 10'd467;

  typedef enum logic [1:0] {
    MODE_ESCAPE  = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_TURN    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_CRIT_THR   = 3'd0,
    CFG_MIN_VALID  = 3'd1,
    CFG_FWD_THR    = 3'd2,
    CFG_GAIN       = 3'd3,
    CFG_FWD_PITCH  = 3'd4,
    CFG_TURN_CMD   = 3'd5,
    CFG_CONE_FIRST = 3'd6,
    CFG_CONE_LAST  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        crit_thr;
    logic [15:0]        min_valid;
    logic [15:0]        fwd_thr;
    logic [14:0]        gain;
    logic signed [15:0] fwd_pitch;
    logic signed [15:0] turn_cmd;
    logic [9:0]         cone_first;
    logic [9:0]         cone_last;
  } cfg_t;

  typedef struct packed {
    logic        crit;
    logic        blocked;
    logic [31:0] acc;
  } scan_sum_t;

  typedef struct packed {
    logic [6:0] sin_idx;
    logic       sin_neg;
    logic [6:0] cos_idx;
    logic       cos_neg;
  } trig_addr_t;

  localparam logic [15:0] SINE_LUT [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32716, 16'd32748, 16'd32763, 16'd32768
  };

  function automatic logic [15:0] sine_q15(input logic [6:0] k);
    logic [15:0] s;
    if (k > 7'd90) begin
      s = 16'd0;
    end else begin
      s = SINE_LUT[k];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/soac_scan.sv */
`default_nettype none
module soac_scan
  import soac_pkg::*;
#(
  parameter int unsigned SCAN_POINTS = SCAN_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [15:0] range_mm,
  input  wire logic        last_sample,
  input  wire cfg_t        cfg,
  output scan_sum_t        sum
);

  localparam int unsigned IDX_W = $clog2(SCAN_POINTS);

  logic [IDX_W-1:0] idx_r;
  logic [31:0]      acc_r;
  logic [31:0]      crit_acc_r;
  logic             crit_seen_r;
  logic             blocked_r;
  logic             crit_hit;
  logic             cone_hit;
  logic             at_end;

  assign crit_hit = (range_mm > cfg.min_valid) && (range_mm < cfg.crit_thr);
  assign cone_hit = (10'(idx_r) >= cfg.cone_first) && (10'(idx_r) <= cfg.cone_last) &&
                    (range_mm < cfg.fwd_thr);
  assign at_end   = (idx_r == IDX_W'(SCAN_POINTS - 1));

  assign sum.crit    = crit_seen_r | crit_hit;
  assign sum.blocked = blocked_r | cone_hit;
  assign sum.acc     = crit_hit ? acc_r : crit_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      acc_r       <= 32'(START_ANGLE_Q16);
      crit_seen_r <= 1'b0;
      blocked_r   <= 1'b0;
    end else if (accept) begin
      if (last_sample) begin
        idx_r       <= '0;
        acc_r       <= 32'(START_ANGLE_Q16);
        crit_seen_r <= 1'b0;
        blocked_r   <= 1'b0;
      end else begin
        if (crit_hit) begin
          crit_seen_r <= 1'b1;
        end
        if (cone_hit) begin
          blocked_r <= 1'b1;
        end
        if (!at_end) begin
          idx_r <= idx_r + 1'b1;
          acc_r <= acc_r + 32'(ANGLE_STEP_Q16);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_acc_r <= '0;
    end else if (accept && !last_sample && crit_hit) begin
      crit_acc_r <= acc_r;
    end
  end

endmodule
`default_nettype wire

/* sv/soac_bearing.sv */
`default_nettype none
module soac_bearing
  import soac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [5:2]  en,
  input  wire logic [31:0] acc,
  output trig_addr_t       addr
);

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } fold_t;

  function automatic fold_t fold(input logic [8:0] u);
    logic [8:0] v;
    fold_t      f;
    if (u <= 9'd90) begin
      v     = u;
      f.neg = 1'b0;
    end else if (u <= 9'd180) begin
      v     = 9'd180 - u;
      f.neg = 1'b0;
    end else if (u <= 9'd270) begin
      v     = u - 9'd180;
      f.neg = 1'b1;
    end else begin
      v     = 9'd360 - u;
      f.neg = 1'b1;
    end
    f.idx = v[6:0];
    return f;
  endfunction

  logic [15:0] mag2_r;
  logic        neg2_r;
  logic [7:0]  q3_r;
  logic [15:0] mag3_r;
  logic        neg3_r;
  logic [8:0]  r4_r;
  logic        neg4_r;
  trig_addr_t  addr5_r;

  logic [31:0] acc_neg;
  logic [29:0] prod3;
  logic [16:0] qm4;
  logic [16:0] rem4;
  logic [16:0] rem4_fix;
  logic [8:0]  t5;
  logic [9:0]  us_raw;
  logic [9:0]  uc_raw;
  logic [9:0]  us;
  logic [9:0]  uc;
  fold_t       fs;
  fold_t       fc;

  // magnitude of the whole-degree part, truncated toward zero
  assign acc_neg = 32'd0 - acc;
  assign prod3   = 30'(mag2_r) * 30'(DEG_RECIP);
  assign qm4     = 17'(q3_r) * 17'd360;
  assign rem4    = 17'(mag3_r) - qm4;
  assign rem4_fix = (rem4 >= 17'd360) ? rem4 - 17'd360 : rem4;

  always_comb begin
    t5     = (neg4_r && (r4_r != 9'd0)) ? 9'd360 - r4_r : r4_r;
    us_raw = 10'(t5) + 10'd180;
    uc_raw = 10'(t5) + 10'd270;
    us     = (us_raw >= 10'd360) ? us_raw - 10'd360 : us_raw;
    uc     = (uc_raw >= 10'd360) ? uc_raw - 10'd360 : uc_raw;
    fs     = fold(us[8:0]);
    fc     = fold(uc[8:0]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag2_r <= acc[31] ? acc_neg[31:16] : acc[31:16];
      neg2_r <= acc[31];
    end
    if (en[3]) begin
      q3_r   <= prod3[29:22];
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
    end
    if (en[4]) begin
      r4_r   <= rem4_fix[8:0];
      neg4_r <= neg3_r;
    end
    if (en[5]) begin
      addr5_r.sin_idx <= fs.idx;
      addr5_r.sin_neg <= fs.neg;
      addr5_r.cos_idx <= fc.idx;
      addr5_r.cos_neg <= fc.neg;
    end
  end

  assign addr = addr5_r;

endmodule
`default_nettype wire

/* sv/soac_sine_rom.sv */
`default_nettype none
module soac_sine_rom
  import soac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire trig_addr_t  addr,
  output logic [15:0]      sin_mag,
  output logic [15:0]      cos_mag
);

  logic [15:0] sin_r;
  logic [15:0] cos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sine_q15(addr.sin_idx);
      cos_r <= sine_q15(addr.cos_idx);
    end
  end

  assign sin_mag = sin_r;
  assign cos_mag = cos_r;

endmodule
`default_nettype wire

/* sv/soac_scale.sv */
`default_nettype none
module soac_scale
  import soac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [14:0] gain,
  input  wire logic [15:0] sin_mag,
  input  wire logic [15:0] cos_mag,
  output logic [15:0]      roll_mag,
  output logic [15:0]      pitch_mag
);

  logic [31:0] roll_prod;
  logic [31:0] pitch_prod;
  logic [15:0] roll_r;
  logic [15:0] pitch_r;

  // q15 product, rounded half up
  assign roll_prod  = 32'(gain) * 32'(sin_mag) + 32'd16384;
  assign pitch_prod = 32'(gain) * 32'(cos_mag) + 32'd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_prod[30:15];
      pitch_r <= pitch_prod[30:15];
    end
  end

  assign roll_mag  = roll_r;
  assign pitch_mag = pitch_r;

endmodule
`default_nettype wire

/* sv/scan_obstacle_avoid_command_unit.sv */
// Laser scan obstacle avoidance command unit. Range samples of one scan enter
// one per clock while in_stall is low, with no gaps required; each sample only
// updates the running bearing, the critical and forward-cone flags. The sample
// marked last closes the scan and launches one command into an eight-stage
// result pipeline (degree reduction, sine table read, gain multiply, output
// register). A new scan may start on the very next cycle; up to eight commands
// can be in flight, and the input stalls only when the first pipeline stage is
// full, which happens only under a sustained output stall. Configuration
// is taken on any cycle with cfg_we high and should only change while no
// command is in flight.
`default_nettype none
module scan_obstacle_avoid_command_unit
  import soac_pkg::*;
#(
  parameter int unsigned SCAN_POINTS = SCAN_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_range_mm,
  input  wire logic               in_last_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_pitch_cmd,
  output logic signed [15:0]      out_roll_cmd,
  output logic signed [15:0]      out_yaw_cmd,
  output logic [1:0]              out_mode,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  cfg_t        cfg_r;
  scan_sum_t   sum;
  trig_addr_t  addr5;

  logic [8:1]  vld_r;
  logic [8:1]  vld_nxt;
  logic [8:1]  en;
  logic        accept;
  logic        push;

  logic [31:0] acc1_r;
  mode_t       mode_r [1:7];
  mode_t       mode1_nxt;
  logic [1:0]  sgn6_r;
  logic [1:0]  sgn7_r;
  logic [15:0] sin_mag;
  logic [15:0] cos_mag;
  logic [15:0] roll_mag;
  logic [15:0] pitch_mag;

  logic signed [15:0] pitch_nxt;
  logic signed [15:0] roll_nxt;
  logic signed [15:0] yaw_nxt;
  logic signed [15:0] pitch_r;
  logic signed [15:0] roll_r;
  logic signed [15:0] yaw_r;
  logic [1:0]         mode_out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crit_thr   <= CRIT_THR_RST;
      cfg_r.min_valid  <= MIN_VALID_RST;
      cfg_r.fwd_thr    <= FWD_THR_RST;
      cfg_r.gain       <= GAIN_RST;
      cfg_r.fwd_pitch  <= FWD_PITCH_RST;
      cfg_r.turn_cmd   <= TURN_CMD_RST;
      cfg_r.cone_first <= CONE_FIRST_RST;
      cfg_r.cone_last  <= CONE_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CRIT_THR:   cfg_r.crit_thr   <= cfg_wdata;
        CFG_MIN_VALID:  cfg_r.min_valid  <= cfg_wdata;
        CFG_FWD_THR:    cfg_r.fwd_thr    <= cfg_wdata;
        CFG_GAIN:       cfg_r.gain       <= cfg_wdata[14:0];
        CFG_FWD_PITCH:  cfg_r.fwd_pitch  <= $signed(cfg_wdata);
        CFG_TURN_CMD:   cfg_r.turn_cmd   <= $signed(cfg_wdata);
        CFG_CONE_FIRST: cfg_r.cone_first <= cfg_wdata[9:0];
        CFG_CONE_LAST:  cfg_r.cone_last  <= cfg_wdata[9:0];
      endcase
    end
  end

  // pipeline flow control, bubbles collapse
  always_comb begin
    en[8] = !vld_r[8] || !out_stall;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];
  assign accept   = in_valid && en[1];
  assign push     = accept && in_last_sample;

  always_comb begin
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = push;
    end
    for (int k = 2; k <= 8; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  soac_scan #(
    .SCAN_POINTS (SCAN_POINTS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .range_mm    (in_range_mm),
    .last_sample (in_last_sample),
    .cfg         (cfg_r),
    .sum         (sum)
  );

  always_comb begin
    if (sum.crit) begin
      mode1_nxt = MODE_ESCAPE;
    end else if (!sum.blocked) begin
      mode1_nxt = MODE_FORWARD;
    end else begin
      mode1_nxt = MODE_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      acc1_r    <= sum.acc;
      mode_r[1] <= mode1_nxt;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        mode_r[k] <= mode_r[k-1];
      end
    end
    if (en[6]) begin
      sgn6_r <= {addr5.sin_neg, addr5.cos_neg};
    end
    if (en[7]) begin
      sgn7_r <= sgn6_r;
    end
  end

  soac_bearing u_bearing (
    .clk  (clk),
    .en   (en[5:2]),
    .acc  (acc1_r),
    .addr (addr5)
  );

  soac_sine_rom u_rom (
    .clk     (clk),
    .en      (en[6]),
    .addr    (addr5),
    .sin_mag (sin_mag),
    .cos_mag (cos_mag)
  );

  soac_scale u_scale (
    .clk       (clk),
    .en        (en[7]),
    .gain      (cfg_r.gain),
    .sin_mag   (sin_mag),
    .cos_mag   (cos_mag),
    .roll_mag  (roll_mag),
    .pitch_mag (pitch_mag)
  );

  // command select
  always_comb begin
    pitch_nxt = '0;
    roll_nxt  = '0;
    yaw_nxt   = '0;
    case (mode_r[7])
      MODE_ESCAPE: begin
        pitch_nxt = sgn7_r[0] ? $signed(16'd0 - pitch_mag) : $signed(pitch_mag);
        roll_nxt  = sgn7_r[1] ? $signed(16'd0 - roll_mag) : $signed(roll_mag);
      end
      MODE_FORWARD: begin
        pitch_nxt = cfg_r.fwd_pitch;
      end
      MODE_TURN: begin
        yaw_nxt = cfg_r.turn_cmd;
      end
      default: begin
        pitch_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      pitch_r    <= pitch_nxt;
      roll_r     <= roll_nxt;
      yaw_r      <= yaw_nxt;
      mode_out_r <= mode_r[7];
    end
  end

  assign out_valid     = vld_r[8];
  assign out_pitch_cmd = pitch_r;
  assign out_roll_cmd  = roll_r;
  assign out_yaw_cmd   = yaw_r;
  assign out_mode      = mode_out_r;

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] && !en[1] |=> vld_r[1] && $stable(acc1_r))
    else $error("stalled first stage lost its request");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> vld_r[1])
    else $error("last sample did not enter the result pipeline");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !vld_r[7] |=> !out_valid)
    else $error("command repeated after it was taken");

endmodule
`default_nettype wire

/* dv/avoid_command_checker.sv */
`timescale 1ns / 100ps
module avoid_command_checker
  import soac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] in_range_mm,
  input  wire logic        in_last_sample,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_pitch_cmd,
  input  wire logic [15:0] out_roll_cmd,
  input  wire logic [15:0] out_yaw_cmd,
  input  wire logic [1:0]  out_mode,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    mode_t              mode;
  } avoid_cmd_t;

  localparam logic [15:0] QUARTER_SINE [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32716, 16'd32748, 16'd32763, 16'd32768
  };

  cfg_t        regs;
  logic [9:0]  scan_idx;
  logic [31:0] bearing_q16;
  logic        crit_hit;
  int          crit_deg;
  logic        cone_hit;
  avoid_cmd_t  expected_cmds [$];
  avoid_cmd_t  want;
  int          shown;

  function automatic int bearing_deg(input logic [31:0] acc);
    int d;
    if (acc[31]) begin
      d = -int'((~acc + 32'd1) >> 16);
    end else begin
      d = int'(acc >> 16);
    end
    d = d % 360;
    if (d > 180) d = d - 360;
    if (d <= -180) d = d + 360;
    return d;
  endfunction

  function automatic int sin_q15(input int a);
    int u;
    u = ((a % 360) + 360) % 360;
    if (u <= 90) return int'(QUARTER_SINE[u]);
    if (u <= 180) return int'(QUARTER_SINE[180 - u]);
    if (u <= 270) return -int'(QUARTER_SINE[u - 180]);
    return -int'(QUARTER_SINE[360 - u]);
  endfunction

  // magnitude rounded half up, sign applied afterwards
  function automatic logic signed [15:0] gain_scale(input logic [14:0] g, input int s);
    logic [31:0] mag;
    logic [31:0] p;
    mag = 32'((s < 0) ? -s : s);
    p = (32'(g) * mag + 32'd16384) >> 15;
    return (s < 0) ? 16'(-p) : 16'(p);
  endfunction

  task automatic start_scan();
    scan_idx    = '0;
    bearing_q16 = 32'(START_ANGLE_Q16);
    crit_hit    = 1'b0;
    crit_deg    = 0;
    cone_hit    = 1'b0;
  endtask

  task automatic predict_command(input logic [15:0] range_mm, input logic last);
    avoid_cmd_t cmd;
    int         opp;
    if (range_mm > regs.min_valid && range_mm < regs.crit_thr) begin
      crit_hit = 1'b1;
      crit_deg = bearing_deg(bearing_q16);
    end
    if (scan_idx >= regs.cone_first && scan_idx <= regs.cone_last &&
        range_mm < regs.fwd_thr) begin
      cone_hit = 1'b1;
    end
    if (!last) begin
      // index and bearing hold at the final scan position
      if (32'(scan_idx) + 32'd1 < SCAN_POINTS_DEF) begin
        scan_idx    = scan_idx + 10'd1;
        bearing_q16 = bearing_q16 + 32'(ANGLE_STEP_Q16);
      end
    end else begin
      cmd.pitch = '0;
      cmd.roll  = '0;
      cmd.yaw   = '0;
      if (crit_hit) begin
        opp = crit_deg + 180;
        if (opp > 180) opp = opp - 360;
        cmd.pitch = gain_scale(regs.gain, sin_q15(opp + 90));
        cmd.roll  = gain_scale(regs.gain, sin_q15(opp));
        cmd.mode  = MODE_ESCAPE;
      end else if (!cone_hit) begin
        cmd.pitch = regs.fwd_pitch;
        cmd.mode  = MODE_FORWARD;
      end else begin
        cmd.yaw  = regs.turn_cmd;
        cmd.mode = MODE_TURN;
      end
      expected_cmds.insert(expected_cmds.size(), cmd);
      start_scan();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.crit_thr   = CRIT_THR_RST;
      regs.min_valid  = MIN_VALID_RST;
      regs.fwd_thr    = FWD_THR_RST;
      regs.gain       = GAIN_RST;
      regs.fwd_pitch  = FWD_PITCH_RST;
      regs.turn_cmd   = TURN_CMD_RST;
      regs.cone_first = CONE_FIRST_RST;
      regs.cone_last  = CONE_LAST_RST;
      start_scan();
      expected_cmds.delete();
      fail_count = 0;
      shown      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CRIT_THR:   regs.crit_thr   = cfg_wdata;
          CFG_MIN_VALID:  regs.min_valid  = cfg_wdata;
          CFG_FWD_THR:    regs.fwd_thr    = cfg_wdata;
          CFG_GAIN:       regs.gain       = cfg_wdata[14:0];
          CFG_FWD_PITCH:  regs.fwd_pitch  = cfg_wdata;
          CFG_TURN_CMD:   regs.turn_cmd   = cfg_wdata;
          CFG_CONE_FIRST: regs.cone_first = cfg_wdata[9:0];
          CFG_CONE_LAST:  regs.cone_last  = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          fail_count = fail_count + 1;
          if (shown < 10) begin
            $display("unexpected command: pitch %0d roll %0d yaw %0d mode %0d",
                     $signed(out_pitch_cmd), $signed(out_roll_cmd),
                     $signed(out_yaw_cmd), out_mode);
            shown = shown + 1;
          end
        end else begin
          want = expected_cmds.pop_front();
          if (out_pitch_cmd !== want.pitch || out_roll_cmd !== want.roll ||
              out_yaw_cmd !== want.yaw || out_mode !== want.mode) begin
            fail_count = fail_count + 1;
            if (shown < 10) begin
              $display("command mismatch: exp pitch %0d roll %0d yaw %0d mode %0d",
                       want.pitch, want.roll, want.yaw, want.mode);
              $display("                  got pitch %0d roll %0d yaw %0d mode %0d",
                       $signed(out_pitch_cmd), $signed(out_roll_cmd),
                       $signed(out_yaw_cmd), out_mode);
              shown = shown + 1;
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_command(in_range_mm, in_last_sample);
      end
    end
    pending = expected_cmds.size();
  end

endmodule

/* dv/scan_obstacle_avoid_command_unit_tb.sv */
`timescale 1ns / 100ps
module scan_obstacle_avoid_command_unit_tb;
  import soac_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [15:0]        in_range_mm    = '0;
  logic               in_last_sample = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [15:0] out_pitch_cmd;
  logic signed [15:0] out_roll_cmd;
  logic signed [15:0] out_yaw_cmd;
  logic [1:0]         out_mode;
  logic               cfg_we         = 1'b0;
  logic [2:0]         cfg_index      = '0;
  logic [15:0]        cfg_wdata      = '0;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int unsigned stall_left  = 0;
  logic        took_result = 1'b0;
  logic        quiet       = 1'b0;

  // thresholds currently programmed, used to aim samples at the compares
  logic [15:0] crit_set = CRIT_THR_RST;
  logic [15:0] minv_set = MIN_VALID_RST;
  logic [15:0] fwd_set  = FWD_THR_RST;

  always #1 clk = ~clk;

  scan_obstacle_avoid_command_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range_mm    (in_range_mm),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pitch_cmd  (out_pitch_cmd),
    .out_roll_cmd   (out_roll_cmd),
    .out_yaw_cmd    (out_yaw_cmd),
    .out_mode       (out_mode),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  avoid_command_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_range_mm    (in_range_mm),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pitch_cmd  (out_pitch_cmd),
    .out_roll_cmd   (out_roll_cmd),
    .out_yaw_cmd    (out_yaw_cmd),
    .out_mode       (out_mode),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    took_result <= out_valid && !out_stall;
  end

  // command receiver applies a random out_stall after each accepted command, none while quiet
  always @(negedge clk) begin
    if (took_result) stall_left = quiet ? 0 : $urandom_range(0, 3);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left = stall_left - 1;
  end

  task automatic send_sample(input logic [15:0] r, input logic l);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_range_mm    <= r;
    in_last_sample <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t k, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= k;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] crit, minv, fwd, gain, pitch, yaw,
                              cfirst, clast);
    write_reg(CFG_CRIT_THR, crit);
    write_reg(CFG_MIN_VALID, minv);
    write_reg(CFG_FWD_THR, fwd);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_FWD_PITCH, pitch);
    write_reg(CFG_TURN_CMD, yaw);
    write_reg(CFG_CONE_FIRST, cfirst);
    write_reg(CFG_CONE_LAST, clast);
    cfg_we   <= 1'b0;
    crit_set = crit;
    minv_set = minv;
    fwd_set  = fwd;
  endtask

  function automatic logic [15:0] pick_range(input logic danger);
    int unsigned sel;
    sel = danger ? $urandom_range(0, 7) : $urandom_range(2, 7);
    case (sel)
      0:       return crit_set - 16'(1 + $urandom_range(0, 2));
      1:       return minv_set + 16'($urandom_range(0, 2));
      2:       return fwd_set - 16'($urandom_range(0, 2));
      3:       return fwd_set + 16'($urandom_range(1, 2));
      4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      5:       return minv_set - 16'($urandom_range(0, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic run_scan_phase(input int unsigned min_items, min_scans, input logic overlong);
    int unsigned items;
    int unsigned scans;
    int unsigned len;
    logic        danger;
    items = 0;
    scans = 0;
    while (items < min_items || scans < min_scans) begin
      // one scan runs past the last scan position
      len    = (overlong && scans == 0) ? SCAN_POINTS_DEF + 8 : pick_length();
      danger = ($urandom_range(0, 2) == 0);
      quiet  = ($urandom_range(0, 4) == 0);
      for (int unsigned k = 0; k < len; k++) begin
        send_sample(pick_range(danger), k == len - 1);
      end
      items = items + len;
      scans = scans + 1;
    end
    quiet = 1'b0;
    settle();
  endtask

  initial begin
    logic [15:0] crit;
    logic [15:0] cfirst;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-sample scans around the escape window, reset settings
    send_sample(16'd0, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd50, 1'b1);
    send_sample(16'd51, 1'b1);
    send_sample(16'd249, 1'b1);
    send_sample(16'd250, 1'b1);
    // last critical sample sets the escape bearing
    send_sample(16'd100, 1'b0);
    send_sample(16'd300, 1'b0);
    send_sample(16'd200, 1'b0);
    send_sample(16'd1000, 1'b1);
    settle();

    // narrow forward cone over indexes 1..2
    write_reg(CFG_CONE_FIRST, 16'd1);
    write_reg(CFG_CONE_LAST, 16'd2);
    cfg_we <= 1'b0;
    send_sample(16'd2000, 1'b0);
    send_sample(16'd999, 1'b0);
    send_sample(16'd2000, 1'b1);
    send_sample(16'd999, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd999, 1'b1);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd999, 1'b1);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd100, 1'b1);
    settle();

    program_regs(CRIT_THR_RST, MIN_VALID_RST, FWD_THR_RST, 16'(GAIN_RST),
                 FWD_PITCH_RST, TURN_CMD_RST, 16'(CONE_FIRST_RST), 16'(CONE_LAST_RST));
    run_scan_phase(0, 3, 1'b1);

    program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000,
                 16'h0000, 16'hFFFF);
    run_scan_phase(16, 3, 1'b0);

    // empty cone, no escape window
    program_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF,
                 16'h03FF, 16'h0000);
    run_scan_phase(16, 3, 1'b0);

    program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000);
    run_scan_phase(16, 3, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      crit   = 16'($urandom);
      cfirst = (ph == 2) ? 16'($urandom) : 16'($urandom_range(0, 12));
      program_regs(crit, 16'($urandom_range(0, crit)), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), cfirst,
                   (ph == 2) ? 16'($urandom) : cfirst + 16'($urandom_range(0, 24)));
      run_scan_phase(16, 3, 1'b0);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* scan_obstacle_avoid_command_unit.f */
sv/soac_pkg.sv
sv/soac_scan.sv
sv/soac_bearing.sv
sv/soac_sine_rom.sv
sv/soac_scale.sv
sv/scan_obstacle_avoid_command_unit.sv
dv/avoid_command_checker.sv
dv/scan_obstacle_avoid_command_unit_tb.sv
